### rtl/buddy_block_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Concurrent property checks, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("bba: implication check failed");
`define BBA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("bba: next-cycle check failed");
`else
`define BBA_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define BBA_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants, FSM state type and request structs.
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;
	localparam int PoolPages   = 16;
	localparam int MaxLevel    = 7;
	localparam int SmallestExp = 5;
	localparam int HeaderBytes = 12;
	localparam int PageShift   = SmallestExp + MaxLevel;
	localparam int UnitsPage   = 1 << MaxLevel;
	localparam int FmRows      = 128;
	localparam int LmDepth     = PoolPages * UnitsPage;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OOM       = 2'd1,
		STAT_TOO_LARGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_A_SCAN,
		ST_A_PICK,
		ST_S_RD,
		ST_S_WR,
		ST_A_LVL,
		ST_F_LCHK,
		ST_F_CHK
	} state_t;

	// free map row index: {level, page}
	typedef logic [6:0] row_idx_t;

	typedef struct packed {
		logic                 rd_en;
		row_idx_t             rd_row;
		logic                 wr_en;
		row_idx_t             wr_row;
		logic [UnitsPage-1:0] wr_data;
		logic                 clr_en;
		logic [3:0]           clr_page;
	} fm_req_t;

	typedef struct packed {
		logic        rd_en;
		logic [10:0] rd_addr;
		logic        wr_en;
		logic [10:0] wr_addr;
		logic [2:0]  wr_data;
	} lm_req_t;
endpackage
`default_nettype wire

### rtl/bba_free_mem.sv
// ----------------------------------------------------------------------------
// Free map store
// One row per (level, page) of free bits, with row valid and nonempty flags.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_free_mem (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bba_pkg::fm_req_t  req,
	output logic [127:0]           rdata,
	output logic [127:0]           summary
);
	import bba_pkg::*;

	logic [UnitsPage-1:0] mem_q [FmRows];
	logic [UnitsPage-1:0] rdata_q;
	logic [FmRows-1:0]    valid_q;
	logic [FmRows-1:0]    summary_q;
	logic                 rvalid_q;

	// row storage, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_row] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.rd_row];
		end
	end

	// valid and nonempty flags; page clear wins over a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			summary_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.rd_row];
			end
			if (req.wr_en) begin
				valid_q[req.wr_row]   <= 1'b1;
				summary_q[req.wr_row] <= |req.wr_data;
			end
			if (req.clr_en) begin
				for (int r = 0; r < FmRows; r++) begin
					if (4'(r) == req.clr_page) begin
						valid_q[r]   <= 1'b0;
						summary_q[r] <= 1'b0;
					end
				end
			end
		end
	end

	assign rdata   = rvalid_q ? rdata_q : '0;
	assign summary = summary_q;
endmodule
`default_nettype wire

### rtl/bba_level_mem.sv
// ----------------------------------------------------------------------------
// Block level store
// Level of the block at each smallest unit, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_level_mem (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bba_pkg::lm_req_t req,
	output logic [2:0]            rdata,
	output logic                  init_busy
);
	import bba_pkg::*;

	logic [2:0]  mem_q [LmDepth];
	logic [2:0]  rdata_q;
	logic [10:0] cnt_q;
	logic        init_q;

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			init_q <= 1'b1;
		end else if (init_q) begin
			cnt_q <= cnt_q + 11'd1;
			if (cnt_q == 11'(LmDepth - 1)) begin
				init_q <= 1'b0;
			end
		end
	end

	// storage, sweep has the write port while active
	always_ff @(posedge clk) begin
		if (init_q) begin
			mem_q[cnt_q] <= '0;
		end else if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.rd_addr];
		end
	end

	assign rdata     = rdata_q;
	assign init_busy = init_q;
endmodule
`default_nettype wire

### rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks levels for split and merge, at most one row read and one write per step.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             op,
	input  wire logic [13:0]      size,
	input  wire logic [15:0]      addr,
	input  wire logic [4:0]       pool_pages,
	input  wire logic             init_busy,
	input  wire logic [127:0]     fm_rdata,
	input  wire logic [127:0]     fm_summary,
	input  wire logic [2:0]       lm_rdata,
	output logic                  busy,
	output logic                  done,
	output logic [15:0]           addr_out,
	output logic [1:0]            status,
	output bba_pkg::fm_req_t      fm_req,
	output bba_pkg::lm_req_t      lm_req
);
	import bba_pkg::*;

	state_t       state_q, state_d;
	logic         op_q, op_d;
	logic [13:0]  size_q, size_d;
	logic [3:0]   page_q, page_d;
	logic [11:0]  within_q, within_d;
	logic [2:0]   lvl_q, lvl_d;
	logic [2:0]   j_q, j_d;
	logic         first_q, first_d;
	logic [15:0]  taken_q, taken_d;
	logic         done_q, done_d;
	logic [15:0]  addr_out_q, addr_out_d;
	status_t      status_q, status_d;

	logic         accept;
	logic [15:0]  blk;
	logic [2:0]   lvl_calc;
	logic         too_large;
	logic [15:0]  lvl_slice;
	logic [3:0]   page_pick;
	logic         page_hit;
	logic [4:0]   limit;
	logic [3:0]   take_pick;
	logic         take_ok;
	logic [6:0]   bit_pick;
	logic [3:0]   shamt;
	logic [3:0]   shamt_m1;
	logic [6:0]   idx;
	logic [6:0]   split_idx;
	logic [11:0]  align_mask;

	assign accept = start && !busy;
	assign blk    = addr - 16'(HeaderBytes);

	// size to level: smallest block that holds the request
	always_comb begin
		lvl_calc = '0;
		for (int l = 0; l < MaxLevel; l++) begin
			if ((15'd32 << l) < {1'b0, size_q}) begin
				lvl_calc = 3'(l + 1);
			end
		end
	end
	assign too_large = size_q > 14'(1 << PageShift);

	// lowest page with a free block at the scanned level
	assign lvl_slice = fm_summary[{j_q, 4'd0} +: 16];
	always_comb begin
		page_pick = '0;
		page_hit  = 1'b0;
		for (int p = PoolPages - 1; p >= 0; p--) begin
			if (lvl_slice[p]) begin
				page_pick = 4'(p);
				page_hit  = 1'b1;
			end
		end
	end

	// lowest untaken pool page within the limit
	assign limit = (pool_pages > 5'(PoolPages)) ? 5'(PoolPages) : pool_pages;
	always_comb begin
		take_pick = '0;
		take_ok   = 1'b0;
		for (int p = PoolPages - 1; p >= 0; p--) begin
			if (5'(p) < limit && !taken_q[p]) begin
				take_pick = 4'(p);
				take_ok   = 1'b1;
			end
		end
	end

	// lowest free block in the row just read
	always_comb begin
		bit_pick = '0;
		for (int i = UnitsPage - 1; i >= 0; i--) begin
			if (fm_rdata[i]) begin
				bit_pick = 7'(i);
			end
		end
	end

	// shared shift unit: block index at the current level
	assign shamt      = 4'(SmallestExp) + {1'b0, j_q};
	assign shamt_m1   = shamt - 4'd1;
	assign idx        = 7'(within_q >> shamt);
	assign split_idx  = 7'(within_q >> shamt_m1) | 7'd1;
	assign align_mask = (12'd32 << lm_rdata) - 12'd1;

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			taken_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			taken_q <= taken_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		size_q     <= size_d;
		page_q     <= page_d;
		within_q   <= within_d;
		lvl_q      <= lvl_d;
		j_q        <= j_d;
		first_q    <= first_d;
		addr_out_q <= addr_out_d;
		status_q   <= status_d;
	end

	// next state and memory requests
	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		size_d     = size_q;
		page_d     = page_q;
		within_d   = within_q;
		lvl_d      = lvl_q;
		j_d        = j_q;
		first_d    = first_q;
		taken_d    = taken_q;
		done_d     = 1'b0;
		addr_out_d = addr_out_q;
		status_d   = status_q;
		fm_req     = '0;
		lm_req     = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_d     = op;
					size_d   = size;
					page_d   = blk[15:12];
					within_d = blk[11:0];
					state_d  = ST_DEC;
				end
			end
			ST_DEC: begin
				if (op_q == OP_ALLOC) begin
					if (too_large) begin
						done_d     = 1'b1;
						addr_out_d = '0;
						status_d   = STAT_TOO_LARGE;
						state_d    = ST_IDLE;
					end else begin
						lvl_d   = lvl_calc;
						j_d     = lvl_calc;
						state_d = ST_A_SCAN;
					end
				end else if (!taken_q[page_q]) begin
					done_d     = 1'b1;
					addr_out_d = '0;
					status_d   = STAT_OK;
					state_d    = ST_IDLE;
				end else begin
					lm_req.rd_en   = 1'b1;
					lm_req.rd_addr = {page_q, within_q[11:5]};
					state_d        = ST_F_LCHK;
				end
			end
			ST_A_SCAN: begin
				if (j_q == 3'(MaxLevel)) begin
					// no free block: take a whole page
					if (!take_ok) begin
						done_d     = 1'b1;
						addr_out_d = '0;
						status_d   = STAT_OOM;
						state_d    = ST_IDLE;
					end else begin
						taken_d[take_pick] = 1'b1;
						fm_req.clr_en      = 1'b1;
						fm_req.clr_page    = take_pick;
						page_d             = take_pick;
						within_d           = '0;
						state_d            = (j_q > lvl_q) ? ST_S_RD : ST_A_LVL;
					end
				end else if (page_hit) begin
					page_d        = page_pick;
					fm_req.rd_en  = 1'b1;
					fm_req.rd_row = {j_q, page_pick};
					state_d       = ST_A_PICK;
				end else begin
					j_d = j_q + 3'd1;
				end
			end
			ST_A_PICK: begin
				fm_req.wr_en   = 1'b1;
				fm_req.wr_row  = {j_q, page_q};
				fm_req.wr_data = fm_rdata & ~(128'd1 << bit_pick);
				within_d       = 12'(bit_pick) << shamt;
				state_d        = (j_q > lvl_q) ? ST_S_RD : ST_A_LVL;
			end
			ST_S_RD: begin
				fm_req.rd_en  = 1'b1;
				fm_req.rd_row = {j_q - 3'd1, page_q};
				state_d       = ST_S_WR;
			end
			ST_S_WR: begin
				// free the upper buddy one level down
				fm_req.wr_en   = 1'b1;
				fm_req.wr_row  = {j_q - 3'd1, page_q};
				fm_req.wr_data = fm_rdata | (128'd1 << split_idx);
				j_d            = j_q - 3'd1;
				state_d        = (j_q - 3'd1 > lvl_q) ? ST_S_RD : ST_A_LVL;
			end
			ST_A_LVL: begin
				lm_req.wr_en   = 1'b1;
				lm_req.wr_addr = {page_q, within_q[11:5]};
				lm_req.wr_data = lvl_q;
				done_d         = 1'b1;
				addr_out_d     = {page_q, within_q} + 16'(HeaderBytes);
				status_d       = STAT_OK;
				state_d        = ST_IDLE;
			end
			ST_F_LCHK: begin
				done_d     = 1'b1;
				addr_out_d = '0;
				status_d   = STAT_OK;
				state_d    = ST_IDLE;
				if (lm_rdata == 3'(MaxLevel)) begin
					if (within_q == '0) begin
						taken_d[page_q] = 1'b0;
						fm_req.clr_en   = 1'b1;
						fm_req.clr_page = page_q;
					end
				end else if ((within_q & align_mask) == '0) begin
					done_d        = 1'b0;
					j_d           = lm_rdata;
					first_d       = 1'b1;
					fm_req.rd_en  = 1'b1;
					fm_req.rd_row = {lm_rdata, page_q};
					state_d       = ST_F_CHK;
				end
			end
			ST_F_CHK: begin
				done_d     = 1'b1;
				addr_out_d = '0;
				status_d   = STAT_OK;
				state_d    = ST_IDLE;
				if (first_q && fm_rdata[idx]) begin
					// double free, nothing changes
				end else if (fm_rdata[idx ^ 7'd1]) begin
					if (j_q == 3'(MaxLevel - 1)) begin
						taken_d[page_q] = 1'b0;
						fm_req.clr_en   = 1'b1;
						fm_req.clr_page = page_q;
					end else begin
						// merge and climb one level
						done_d         = 1'b0;
						fm_req.wr_en   = 1'b1;
						fm_req.wr_row  = {j_q, page_q};
						fm_req.wr_data = fm_rdata & ~(128'd1 << (idx ^ 7'd1));
						within_d       = within_q & ~(12'd32 << j_q);
						j_d            = j_q + 3'd1;
						first_d        = 1'b0;
						fm_req.rd_en   = 1'b1;
						fm_req.rd_row  = {j_q + 3'd1, page_q};
						state_d        = ST_F_CHK;
					end
				end else begin
					fm_req.wr_en   = 1'b1;
					fm_req.wr_row  = {j_q, page_q};
					fm_req.wr_data = fm_rdata | (128'd1 << idx);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE) || init_busy;
	assign done     = done_q;
	assign addr_out = addr_out_q;
	assign status   = status_q;
endmodule
`default_nettype wire

### rtl/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocate and free requests over a pool of 4 KiB pages, one at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result is shown
// for one cycle with done high, in the first cycle that busy is low again. The
// receiver cannot stall, so it must take every result as it comes. Busy stays
// high while the sequencer works; each step makes at most one free-map row
// read plus one row write or page clear. An oversize allocate ends at decode.
// Any other allocate scans levels upward from its own (1 to 8 levels), picks
// a block when a free one is found or else takes a whole page, then splits
// once per level down to its own (up to 7 splits) and writes the block level.
// A free ends at decode when its page is not taken, and at the level check
// when it is dropped for level or alignment. Otherwise it merges upward for
// up to 6 levels. After reset busy stays high while the 2048-entry block-level
// store is swept clear. Write pool_pages only while busy is low.
`default_nettype none
`include "buddy_block_allocator_top_assert.svh"
module buddy_block_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [13:0] size,
	input  wire logic [15:0] addr,
	output logic             done,
	output logic [15:0]      addr_out,
	output logic [1:0]       status,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata
);
	import bba_pkg::*;

	logic [4:0]   pool_pages_q;
	fm_req_t      fm_req;
	lm_req_t      lm_req;
	logic [127:0] fm_rdata;
	logic [127:0] fm_summary;
	logic [2:0]   lm_rdata;
	logic         init_busy;

	// pool size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_pages_q <= 5'd16;
		end else if (cfg_we) begin
			pool_pages_q <= cfg_wdata;
		end
	end

	bba_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.size       (size),
		.addr       (addr),
		.pool_pages (pool_pages_q),
		.init_busy  (init_busy),
		.fm_rdata   (fm_rdata),
		.fm_summary (fm_summary),
		.lm_rdata   (lm_rdata),
		.busy       (busy),
		.done       (done),
		.addr_out   (addr_out),
		.status     (status),
		.fm_req     (fm_req),
		.lm_req     (lm_req)
	);

	bba_free_mem u_free_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fm_req),
		.rdata   (fm_rdata),
		.summary (fm_summary)
	);

	bba_level_mem u_level_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (lm_req),
		.rdata     (lm_rdata),
		.init_busy (init_busy)
	);

	// every transfer leads to work, results only at the end of work
	`BBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`BBA_ASSERT_IMPLY(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy)
	`BBA_ASSERT_IMPLY(a_fail_zero_addr, clk, arst_n, done && status != 2'(STAT_OK), addr_out == '0)
endmodule
`default_nettype wire
